// ===== design/cau_pkg.sv =====
package cau_pkg;

    // Default operand format: signed Q8.8.
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK  = 2'd0,
        STATUS_SAT = 2'd1,
        STATUS_DZ  = 2'd2
    } t_status;

    // Control that travels down the pipeline with each transaction.
    typedef struct packed {
        logic  valid;
        t_func func;
        logic  dz;
    } t_ctl;

endpackage

// ===== design/complex_arithmetic_unit.sv =====
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fractional bits; Q8.8 by default). Results
// are truncated toward zero and saturated; status reports saturation or a
// zero divisor. The unit takes one transaction every cycle while the
// output is not stalled. It has one multiplier stage, two combine stages, a
// divider of DATA_WIDTH+2 stages (an entry stage that flags overflow, then
// one quotient bit per stage), and the output register. A stall at the
// output freezes the whole pipeline.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [FUNC_W-1:0]            i_func,
    input  logic signed [DATA_WIDTH-1:0] i_x_re,
    input  logic signed [DATA_WIDTH-1:0] i_x_im,
    input  logic signed [DATA_WIDTH-1:0] i_y_re,
    input  logic signed [DATA_WIDTH-1:0] i_y_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [STATUS_W-1:0]          o_status
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 1;
    localparam int LD = DATA_WIDTH + 2;

    logic w_en;
    t_ctl w_ctl1, w_ctl3;
    logic signed [PW-1:0] w_ac, w_bd, w_ad, w_bc, w_cc, w_dd;
    logic signed [DATA_WIDTH:0] w_as_re, w_as_im;
    logic          w_neg_re, w_neg_im, w_lneg_re, w_lneg_im;
    logic [RW-1:0] w_rem_re, w_rem_im, w_mag_re, w_mag_im;
    logic [PW-1:0] w_den;
    logic          w_is_div;
    t_ctl          r_dly [LD];

    // The pipeline advances unless a held result is being stalled.
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    cau_mult #(.DATA_WIDTH(DATA_WIDTH)) u_mult (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_func(i_func), .i_x_re(i_x_re), .i_x_im(i_x_im),
        .i_y_re(i_y_re), .i_y_im(i_y_im), .o_ctl(w_ctl1),
        .o_ac(w_ac), .o_bd(w_bd), .o_ad(w_ad), .o_bc(w_bc),
        .o_cc(w_cc), .o_dd(w_dd), .o_as_re(w_as_re), .o_as_im(w_as_im)
    );

    cau_comb #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_comb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_ctl(w_ctl1),
        .i_ac(w_ac), .i_bd(w_bd), .i_ad(w_ad), .i_bc(w_bc),
        .i_cc(w_cc), .i_dd(w_dd), .i_as_re(w_as_re), .i_as_im(w_as_im),
        .o_ctl(w_ctl3), .o_neg_re(w_neg_re), .o_rem_re(w_rem_re),
        .o_neg_im(w_neg_im), .o_rem_im(w_rem_im), .o_den(w_den)
    );

    assign w_is_div = (w_ctl3.func == FUNC_DIV);

    // Real and imaginary quotient lanes share the divisor.
    cau_div_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_re (
        .i_clk(i_clk), .i_en(w_en), .i_is_div(w_is_div), .i_neg(w_neg_re),
        .i_rem(w_rem_re), .i_den(w_den), .o_neg(w_lneg_re), .o_mag(w_mag_re)
    );

    cau_div_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_im (
        .i_clk(i_clk), .i_en(w_en), .i_is_div(w_is_div), .i_neg(w_neg_im),
        .i_rem(w_rem_im), .i_den(w_den), .o_neg(w_lneg_im), .o_mag(w_mag_im)
    );

    // Control delay line matching the divider lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LD; i++) begin
                r_dly[i] <= '0;
            end
        end else if (w_en) begin
            r_dly[0] <= w_ctl3;
            for (int i = 1; i < LD; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    cau_sat #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_sat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_ctl(r_dly[LD-1]),
        .i_neg_re(w_lneg_re), .i_mag_re(w_mag_re),
        .i_neg_im(w_lneg_im), .i_mag_im(w_mag_im),
        .o_valid(o_valid), .o_res_re(o_res_re), .o_res_im(o_res_im),
        .o_status(o_status)
    );

endmodule

// ===== design/cau_mult.sv =====
module cau_mult
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [DATA_WIDTH-1:0] i_x_re,
    input  logic signed [DATA_WIDTH-1:0] i_x_im,
    input  logic signed [DATA_WIDTH-1:0] i_y_re,
    input  logic signed [DATA_WIDTH-1:0] i_y_im,
    output t_ctl                      o_ctl,
    output logic signed [2*DATA_WIDTH-1:0] o_ac,
    output logic signed [2*DATA_WIDTH-1:0] o_bd,
    output logic signed [2*DATA_WIDTH-1:0] o_ad,
    output logic signed [2*DATA_WIDTH-1:0] o_bc,
    output logic signed [2*DATA_WIDTH-1:0] o_cc,
    output logic signed [2*DATA_WIDTH-1:0] o_dd,
    output logic signed [DATA_WIDTH:0]     o_as_re,
    output logic signed [DATA_WIDTH:0]     o_as_im
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int AW = DATA_WIDTH + 1;

    t_ctl r_ctl;
    t_ctl n_ctl;
    logic signed [PW-1:0] r_ac, r_bd, r_ad, r_bc, r_cc, r_dd;
    logic signed [AW-1:0] r_as_re, r_as_im;

    assign n_ctl = '{valid: i_valid, func: t_func'(i_func), dz: 1'b0};

    // Control register of the first stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    // All six partial products, plus the sum or difference for add and subtract.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= PW'(i_x_re) * PW'(i_y_re);
            r_bd <= PW'(i_x_im) * PW'(i_y_im);
            r_ad <= PW'(i_x_re) * PW'(i_y_im);
            r_bc <= PW'(i_x_im) * PW'(i_y_re);
            r_cc <= PW'(i_y_re) * PW'(i_y_re);
            r_dd <= PW'(i_y_im) * PW'(i_y_im);
            if (t_func'(i_func) == FUNC_SUB) begin
                r_as_re <= AW'(i_x_re) - AW'(i_y_re);
                r_as_im <= AW'(i_x_im) - AW'(i_y_im);
            end else begin
                r_as_re <= AW'(i_x_re) + AW'(i_y_re);
                r_as_im <= AW'(i_x_im) + AW'(i_y_im);
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_ac    = r_ac;
    assign o_bd    = r_bd;
    assign o_ad    = r_ad;
    assign o_bc    = r_bc;
    assign o_cc    = r_cc;
    assign o_dd    = r_dd;
    assign o_as_re = r_as_re;
    assign o_as_im = r_as_im;

endmodule

// ===== design/cau_comb.sv =====
module cau_comb
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  t_ctl                           i_ctl,
    input  logic signed [2*DATA_WIDTH-1:0] i_ac,
    input  logic signed [2*DATA_WIDTH-1:0] i_bd,
    input  logic signed [2*DATA_WIDTH-1:0] i_ad,
    input  logic signed [2*DATA_WIDTH-1:0] i_bc,
    input  logic signed [2*DATA_WIDTH-1:0] i_cc,
    input  logic signed [2*DATA_WIDTH-1:0] i_dd,
    input  logic signed [DATA_WIDTH:0]     i_as_re,
    input  logic signed [DATA_WIDTH:0]     i_as_im,
    output t_ctl                           o_ctl,
    output logic                           o_neg_re,
    output logic [3*DATA_WIDTH+FRAC_BITS:0] o_rem_re,
    output logic                           o_neg_im,
    output logic [3*DATA_WIDTH+FRAC_BITS:0] o_rem_im,
    output logic [2*DATA_WIDTH-1:0]        o_den
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 1;

    t_ctl r_ctl2, r_ctl3;
    logic signed [SW-1:0] r_s_re, r_s_im;
    logic [PW-1:0]        r_den2, r_den3;
    logic                 r_neg_re, r_neg_im;
    logic [RW-1:0]        r_rem_re, r_rem_im;
    logic signed [SW-1:0] w_ngt_re, w_ngt_im;
    logic [PW-1:0]        w_mag_re, w_mag_im;
    logic [RW-1:0]        w_rem_re, w_rem_im;
    t_ctl                 w_ctl3;

    // Control registers of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= w_ctl3;
        end
    end

    // Stage two: exact signed sums, products or divide numerators, and the divisor |y|^2.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_ctl.func)
                FUNC_MUL: begin
                    r_s_re <= SW'(i_ac) - SW'(i_bd);
                    r_s_im <= SW'(i_ad) + SW'(i_bc);
                end
                FUNC_DIV: begin
                    r_s_re <= SW'(i_ac) + SW'(i_bd);
                    r_s_im <= SW'(i_bc) - SW'(i_ad);
                end
                default: begin
                    r_s_re <= SW'(i_as_re);
                    r_s_im <= SW'(i_as_im);
                end
            endcase
            r_den2 <= $unsigned(i_cc) + $unsigned(i_dd);
        end
    end

    // Stage three: sign and magnitude, scaled for the operation.
    assign w_ngt_re = -r_s_re;
    assign w_ngt_im = -r_s_im;
    assign w_mag_re = r_s_re[SW-1] ? w_ngt_re[PW-1:0] : r_s_re[PW-1:0];
    assign w_mag_im = r_s_im[SW-1] ? w_ngt_im[PW-1:0] : r_s_im[PW-1:0];

    always_comb begin
        case (r_ctl2.func)
            FUNC_DIV: begin
                w_rem_re = RW'(w_mag_re) << FRAC_BITS;
                w_rem_im = RW'(w_mag_im) << FRAC_BITS;
            end
            FUNC_MUL: begin
                w_rem_re = RW'(w_mag_re >> FRAC_BITS);
                w_rem_im = RW'(w_mag_im >> FRAC_BITS);
            end
            default: begin
                w_rem_re = RW'(w_mag_re);
                w_rem_im = RW'(w_mag_im);
            end
        endcase
        w_ctl3    = r_ctl2;
        w_ctl3.dz = (r_ctl2.func == FUNC_DIV) && (r_den2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_re <= r_s_re[SW-1];
            r_neg_im <= r_s_im[SW-1];
            r_rem_re <= w_rem_re;
            r_rem_im <= w_rem_im;
            r_den3   <= r_den2;
        end
    end

    assign o_ctl    = r_ctl3;
    assign o_neg_re = r_neg_re;
    assign o_rem_re = r_rem_re;
    assign o_neg_im = r_neg_im;
    assign o_rem_im = r_rem_im;
    assign o_den    = r_den3;

endmodule

// ===== design/cau_div_lane.sv =====
module cau_div_lane
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_is_div,
    input  logic                            i_neg,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0] i_rem,
    input  logic [2*DATA_WIDTH-1:0]         i_den,
    output logic                            o_neg,
    output logic [3*DATA_WIDTH+FRAC_BITS:0] o_mag
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 1;
    localparam int QW = DATA_WIDTH + 1;
    localparam int NS = DATA_WIDTH + 1;

    logic [RW-1:0] r_rem [NS+1];
    logic [QW-1:0] r_q   [NS+1];
    logic [PW-1:0] r_den [NS+1];
    logic          r_neg [NS+1];
    logic          r_div [NS+1];
    logic          r_ovf [NS+1];
    logic [RW-1:0] w_ovf_lim;
    logic [RW-1:0] w_cap1;

    // Entry stage: flag quotients that cannot fit in DATA_WIDTH+1 bits.
    assign w_ovf_lim = RW'(i_den) << (DATA_WIDTH + 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_rem;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_div[0] <= i_is_div;
            r_ovf[0] <= i_is_div && (i_rem >= w_ovf_lim);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar g = 0; g < NS; g++) begin : g_step
        localparam int K = DATA_WIDTH - g;
        logic [RW-1:0] w_sub;
        logic          w_take;
        logic [QW-1:0] w_q;

        assign w_sub  = RW'(r_den[g]) << K;
        assign w_take = r_div[g] && !r_ovf[g] && (r_rem[g] >= w_sub);
        assign w_q    = r_q[g] | (QW'(w_take) << K);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_take ? (r_rem[g] - w_sub) : r_rem[g];
                r_q[g+1]   <= w_q;
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_div[g+1] <= r_div[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    // An overflowed quotient reads as one above the negative limit.
    assign w_cap1 = (RW'(1) << (DATA_WIDTH - 1)) + RW'(1);
    assign o_neg  = r_neg[NS];
    assign o_mag  = r_div[NS] ? (r_ovf[NS] ? w_cap1 : RW'(r_q[NS])) : r_rem[NS];

endmodule

// ===== design/cau_sat.sv =====
module cau_sat
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  t_ctl                            i_ctl,
    input  logic                            i_neg_re,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0] i_mag_re,
    input  logic                            i_neg_im,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0] i_mag_im,
    output logic                            o_valid,
    output logic signed [DATA_WIDTH-1:0]    o_res_re,
    output logic signed [DATA_WIDTH-1:0]    o_res_im,
    output logic [STATUS_W-1:0]             o_status
);

    localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 1;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_res_re, r_res_im;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] w_res_re, w_res_im;
    logic                  w_sat_re, w_sat_im;

    // Clamp a sign-magnitude value to the two's complement range.
    function automatic logic [DATA_WIDTH:0] f_sat(input logic neg, input logic [RW-1:0] mag);
        logic [RW-1:0] neg_max;
        logic [RW-1:0] pos_max;
        logic [RW-1:0] val;
        logic [RW-1:0] ngv;
        logic          sat;
        neg_max = RW'(1) << (DATA_WIDTH - 1);
        pos_max = neg_max - RW'(1);
        sat     = neg ? (mag > neg_max) : (mag > pos_max);
        val     = sat ? (neg ? neg_max : pos_max) : mag;
        ngv     = RW'(0) - val;
        return {sat, (neg ? ngv[DATA_WIDTH-1:0] : val[DATA_WIDTH-1:0])};
    endfunction

    assign {w_sat_re, w_res_re} = f_sat(i_neg_re, i_mag_re);
    assign {w_sat_im, w_res_im} = f_sat(i_neg_im, i_mag_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Output register; divide by zero forces a zero result.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.dz) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_status <= STATUS_DZ;
            end else begin
                r_res_re <= w_res_re;
                r_res_im <= w_res_im;
                r_status <= (w_sat_re || w_sat_im) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

endmodule
